// ===== rtl/core/cursor_line_edit_buffer_assert.svh =====
// Assertion macros shared by the line edit buffer modules.
// Depends on a clock named clk and an active-low reset named rst_n in the including module.
`ifndef CURSOR_LINE_EDIT_BUFFER_ASSERT_SVH
`define CURSOR_LINE_EDIT_BUFFER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CLEB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line edit buffer check failed");

// Next-cycle implication, checked out of reset.
`define CLEB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line edit buffer check failed");

`endif

// ===== rtl/core/cleb_pkg.sv =====
// Shared types and constants for the line edit buffer.
// Used by the controller, the datapath and the top level; depends on nothing.
package cleb_pkg;

    localparam int OP_W  = 3;
    localparam int BYTE_W = 8;
    localparam int LEN_W = 8;
    localparam int POS_W = 16;

    localparam logic [OP_W-1:0] OP_INSERT    = 3'd0;
    localparam logic [OP_W-1:0] OP_BACKSPACE = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE    = 3'd2;
    localparam logic [OP_W-1:0] OP_SETCUR    = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd4;
    localparam logic [OP_W-1:0] OP_READ      = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the incoming word
        logic shift_init;  // set the shift pointer to its first source
        logic shift_step;  // move the shift pointer one place
        logic rd_ptr;      // read the store at the shift pointer, else at the position
        logic wr_shift;    // write the byte just read to its new place
        logic wr_char;     // write the inserted byte at the cursor
        logic commit;      // update length and cursor, load the result register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic go_shift;    // the edit applies and has a tail to move
        logic go_insert;   // the operation is an insert that applies
        logic shift_right; // the tail moves toward higher addresses
        logic shift_last;  // the pointer holds the last source byte
        logic out_free;    // the result register can take a word this cycle
    } status_t;

endpackage

// ===== rtl/core/cleb_ctrl.sv =====
// Sequencing controller for the line edit buffer.
// Depends on cleb_pkg and cursor_line_edit_buffer_assert.svh.
`include "cursor_line_edit_buffer_assert.svh"

module cleb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  cleb_pkg::status_t st,
    output cleb_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_INS_WR,
        ST_PUBLISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (st.go_shift)
                begin
                    cmd.shift_init = 1'b1;
                    state_next     = ST_SHIFT_RD;
                end
                else if (st.go_insert)
                begin
                    state_next = ST_INS_WR;
                end
                else
                begin
                    state_next = ST_PUBLISH;
                end
            end
            ST_SHIFT_RD:
            begin
                cmd.rd_ptr = 1'b1;
                state_next = ST_SHIFT_WR;
            end
            ST_SHIFT_WR:
            begin
                cmd.wr_shift = 1'b1;
                if (st.shift_last)
                begin
                    state_next = st.shift_right ? ST_INS_WR : ST_PUBLISH;
                end
                else
                begin
                    cmd.shift_step = 1'b1;
                    state_next     = ST_SHIFT_RD;
                end
            end
            ST_INS_WR:
            begin
                cmd.wr_char = 1'b1;
                state_next  = ST_PUBLISH;
            end
            ST_PUBLISH:
            begin
                if (st.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

    `CLEB_ASSERT_NEXT(a_commit_to_idle, cmd.commit, state_reg == ST_IDLE)

endmodule

// ===== rtl/core/cleb_dpath.sv =====
// Datapath of the line edit buffer: text store, length, cursor, limit and result register.
// Depends on cleb_pkg and cursor_line_edit_buffer_assert.svh.
`include "cursor_line_edit_buffer_assert.svh"

module cleb_dpath #(
    parameter int CAPACITY = 128
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [cleb_pkg::LEN_W-1:0]          cfg_wr_data,
    input  logic [cleb_pkg::OP_W-1:0]           opcode,
    input  logic [cleb_pkg::BYTE_W-1:0]         char_code,
    input  logic signed [cleb_pkg::POS_W-1:0]   position,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic                                applied,
    output logic [cleb_pkg::LEN_W-1:0]          line_length,
    output logic [cleb_pkg::LEN_W-1:0]          cursor_pos,
    output logic [cleb_pkg::BYTE_W-1:0]         read_byte,
    input  cleb_pkg::cmd_t                      cmd,
    output cleb_pkg::status_t                   st
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CAP_CLIP = (CAPACITY > 255) ? 255 : CAPACITY;
    localparam logic [cleb_pkg::LEN_W-1:0] CAP_LIM = cleb_pkg::LEN_W'(CAP_CLIP);

    logic [cleb_pkg::BYTE_W-1:0] mem [CAPACITY];
    logic [cleb_pkg::BYTE_W-1:0] rdata_reg;

    logic [cleb_pkg::LEN_W-1:0]        max_chars_reg;
    logic [cleb_pkg::LEN_W-1:0]        len_reg;
    logic [cleb_pkg::LEN_W-1:0]        len_next;
    logic [cleb_pkg::LEN_W-1:0]        cur_reg;
    logic [cleb_pkg::LEN_W-1:0]        cur_next;
    logic [cleb_pkg::LEN_W-1:0]        ptr_reg;
    logic [cleb_pkg::LEN_W-1:0]        ptr_next;
    logic [cleb_pkg::OP_W-1:0]         op_reg;
    logic [cleb_pkg::BYTE_W-1:0]       ch_reg;
    logic signed [cleb_pkg::POS_W-1:0] pos_reg;

    logic                              out_valid_reg;
    logic                              applied_reg;
    logic [cleb_pkg::LEN_W-1:0]        line_length_reg;
    logic [cleb_pkg::LEN_W-1:0]        cursor_pos_reg;
    logic [cleb_pkg::BYTE_W-1:0]       read_byte_reg;

    logic [cleb_pkg::LEN_W-1:0]        lim;
    logic                              is_ins;
    logic                              is_bksp;
    logic                              is_del;
    logic                              ins_ok;
    logic                              bksp_ok;
    logic                              del_ok;
    logic                              rd_ok;
    logic                              applied_next;
    logic [cleb_pkg::BYTE_W-1:0]       rbyte_next;
    logic [cleb_pkg::LEN_W-1:0]        widx;
    logic [cleb_pkg::BYTE_W-1:0]       wdata;
    logic                              mem_we;
    logic [AW-1:0]                     raddr;

    // Effective limit: a limit above the store size acts as the store size.
    assign lim = (max_chars_reg > CAP_LIM) ? CAP_LIM : max_chars_reg;

    assign is_ins  = (op_reg == cleb_pkg::OP_INSERT);
    assign is_bksp = (op_reg == cleb_pkg::OP_BACKSPACE);
    assign is_del  = (op_reg == cleb_pkg::OP_DELETE);

    assign ins_ok  = is_ins && (len_reg < lim) && (cur_reg < lim);
    assign bksp_ok = is_bksp && (len_reg != '0) && (cur_reg != '0);
    assign del_ok  = is_del && (cur_reg < len_reg);
    assign rd_ok   = !pos_reg[cleb_pkg::POS_W-1]
                     && (pos_reg[cleb_pkg::POS_W-2:0] < (cleb_pkg::POS_W-1)'(len_reg));

    assign st.go_shift    = (ins_ok && (len_reg > cur_reg))
                            || (bksp_ok && (cur_reg < len_reg))
                            || (del_ok && ((cur_reg + 8'd1) < len_reg));
    assign st.go_insert   = ins_ok;
    assign st.shift_right = is_ins;
    assign st.shift_last  = is_ins ? (ptr_reg == cur_reg) : ((ptr_reg + 8'd1) == len_reg);
    assign st.out_free    = !out_valid_reg || !out_stall;

    // Shift pointer walks the source bytes of the tail being moved.
    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.shift_init)
        begin
            if (is_ins)
            begin
                ptr_next = len_reg - 8'd1;
            end
            else if (is_bksp)
            begin
                ptr_next = cur_reg;
            end
            else
            begin
                ptr_next = cur_reg + 8'd1;
            end
        end
        else if (cmd.shift_step)
        begin
            ptr_next = is_ins ? (ptr_reg - 8'd1) : (ptr_reg + 8'd1);
        end
    end

    assign widx   = cmd.wr_char ? cur_reg : (is_ins ? (ptr_reg + 8'd1) : (ptr_reg - 8'd1));
    assign wdata  = cmd.wr_char ? ch_reg : rdata_reg;
    assign mem_we = cmd.wr_shift || cmd.wr_char;
    assign raddr  = cmd.rd_ptr ? AW'(ptr_reg) : AW'(pos_reg);

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
        if (mem_we)
        begin
            mem[AW'(widx)] <= wdata;
        end
    end

    // Length, cursor and result of the operation as it completes.
    always_comb
    begin
        len_next     = len_reg;
        cur_next     = cur_reg;
        applied_next = 1'b0;
        rbyte_next   = '0;
        case (op_reg)
            cleb_pkg::OP_INSERT:
            begin
                if (ins_ok)
                begin
                    len_next     = len_reg + 8'd1;
                    cur_next     = cur_reg + 8'd1;
                    applied_next = 1'b1;
                end
            end
            cleb_pkg::OP_BACKSPACE:
            begin
                if (bksp_ok)
                begin
                    len_next     = len_reg - 8'd1;
                    cur_next     = cur_reg - 8'd1;
                    applied_next = 1'b1;
                end
            end
            cleb_pkg::OP_DELETE:
            begin
                if (del_ok)
                begin
                    len_next     = len_reg - 8'd1;
                    applied_next = 1'b1;
                end
            end
            cleb_pkg::OP_SETCUR:
            begin
                if (pos_reg[cleb_pkg::POS_W-1])
                begin
                    cur_next = '0;
                end
                else if (pos_reg[cleb_pkg::POS_W-2:0] > (cleb_pkg::POS_W-1)'(len_reg))
                begin
                    cur_next = len_reg;
                end
                else
                begin
                    cur_next = pos_reg[cleb_pkg::LEN_W-1:0];
                end
                applied_next = 1'b1;
            end
            cleb_pkg::OP_CLEAR:
            begin
                len_next     = '0;
                cur_next     = '0;
                applied_next = 1'b1;
            end
            cleb_pkg::OP_READ:
            begin
                if (rd_ok)
                begin
                    rbyte_next = rdata_reg;
                end
            end
            default:
            begin
                applied_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_chars_reg <= CAP_LIM;
            len_reg       <= '0;
            cur_reg       <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_chars_reg <= cfg_wr_data;
            end
            ptr_reg <= ptr_next;
            if (cmd.commit)
            begin
                len_reg       <= len_next;
                cur_reg       <= cur_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            ch_reg  <= char_code;
            pos_reg <= position;
        end
        if (cmd.commit)
        begin
            applied_reg     <= applied_next;
            line_length_reg <= len_next;
            cursor_pos_reg  <= cur_next;
            read_byte_reg   <= rbyte_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign applied     = applied_reg;
    assign line_length = line_length_reg;
    assign cursor_pos  = cursor_pos_reg;
    assign read_byte   = read_byte_reg;

    `CLEB_ASSERT_NOW(a_cursor_in_line, 1'b1, cur_reg <= len_reg)
    `CLEB_ASSERT_NOW(a_write_in_store, mem_we, 32'(widx) < CAPACITY)
    `CLEB_ASSERT_NEXT(a_insert_grows, cmd.commit && ins_ok, len_reg == $past(len_reg) + 8'd1)

endmodule

// ===== rtl/core/cursor_line_edit_buffer.sv =====
// Top level of the cursor line edit buffer.
// Depends on cleb_pkg, cleb_ctrl and cleb_dpath.
//
// Usage:
// The block keeps one line of text, its length and an edit cursor. Each input
// word (opcode, char_code, position) is one operation: insert, backspace,
// delete, set cursor, clear or read byte. Each word produces exactly one result
// word (applied, line_length, cursor_pos, read_byte), in order.
// Both channels use valid and stall; a word moves on a rising edge where valid
// is high and stall is low. The user must write the limit max_chars through cfg_wr_en
// and cfg_wr_data only while the block is idle; the block does not enforce this.
// Sequencing: the line sits in a single-port-write memory, so edits move the tail
// one byte at a time, each by a read and then a write. A word goes from accept to
// evaluate, then the read and write of each moved byte for backspace, delete and
// insert, the new byte's write for an applied insert, then the commit into the
// result register. The next word is taken in the cycle after the result is loaded;
// in_stall stays high, so no new word is taken before the last one is through.
// Stall on the result side: a finished word waits in the output register while
// the block takes and works on the next word; that word then waits before its
// commit until the output register is free, and holds off further input.
// Reset: length and cursor go to zero and max_chars to the store size (clipped to
// 255). Store contents are not cleared; bytes at or past the length are never
// read, so no clearing pass is needed and the block is ready right after reset.

module cursor_line_edit_buffer #(
    parameter int CAPACITY = 128
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [cleb_pkg::LEN_W-1:0]          cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [cleb_pkg::OP_W-1:0]           opcode,
    input  logic [cleb_pkg::BYTE_W-1:0]         char_code,
    input  logic signed [cleb_pkg::POS_W-1:0]   position,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                applied,
    output logic [cleb_pkg::LEN_W-1:0]          line_length,
    output logic [cleb_pkg::LEN_W-1:0]          cursor_pos,
    output logic [cleb_pkg::BYTE_W-1:0]         read_byte
);

    // Command and status between the sequencer and the datapath.
    cleb_pkg::cmd_t    cmd;
    cleb_pkg::status_t st;

    // The controller walks each word through evaluate, tail moves, the
    // inserted byte write and the commit into the result register.
    cleb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    // The datapath holds the store, length, cursor, limit and result word.
    cleb_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .opcode      (opcode),
        .char_code   (char_code),
        .position    (position),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .applied     (applied),
        .line_length (line_length),
        .cursor_pos  (cursor_pos),
        .read_byte   (read_byte),
        .cmd         (cmd),
        .st          (st)
    );

endmodule
